>>> src/look_at_rotation_matrix_core_defines.svh
// shared assertion macros
`ifndef LOOK_AT_ROTATION_MATRIX_CORE_DEFINES_SVH
`define LOOK_AT_ROTATION_MATRIX_CORE_DEFINES_SVH

// same-cycle implication
`define LAR_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
   else $error("assertion failed");

// next-cycle implication
`define LAR_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
   else $error("assertion failed");

`endif

>>> src/lar_pkg.sv
package lar_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int OUT_FRAC_BITS = 14;
   localparam int OUT_WIDTH     = 16;
   localparam int VEC_WIDTH     = COORD_WIDTH + OUT_WIDTH + 1;
   localparam int MAG_WIDTH     = VEC_WIDTH - 1;
   localparam int POS_WIDTH     = $clog2(MAG_WIDTH);
   localparam int W_WIDTH       = 30;
   localparam int W_TOP         = W_WIDTH - 1;
   localparam int SQ_WIDTH      = 2 * W_WIDTH;
   localparam int SUM_WIDTH     = SQ_WIDTH + 2;
   localparam int ROOT_STEPS    = SUM_WIDTH / 2;
   localparam int ROOT_WIDTH    = ROOT_STEPS;
   localparam int Q_WIDTH       = OUT_FRAC_BITS + 1;
   localparam int NUM_WIDTH     = W_WIDTH + OUT_FRAC_BITS + 1;
   localparam int REM_WIDTH     = ROOT_WIDTH + 1;
   localparam int PROD_WIDTH    = OUT_WIDTH + COORD_WIDTH;
   localparam int Y_WIDTH       = 2 * OUT_WIDTH;
   localparam logic [Q_WIDTH-1:0] ONE = Q_WIDTH'(1) << OUT_FRAC_BITS;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [OUT_WIDTH-1:0]   comp_type;
   typedef logic signed [VEC_WIDTH-1:0]   vec_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
      coord_type up_x;
      coord_type up_y;
      coord_type up_z;
   } req_type;

   typedef struct packed {
      comp_type right_x;
      comp_type right_y;
      comp_type right_z;
      comp_type upward_x;
      comp_type upward_y;
      comp_type upward_z;
      comp_type forward_x;
      comp_type forward_y;
      comp_type forward_z;
      logic     degenerate;
   } rsp_type;

   // data that rides alongside a vector through the normalizer
   typedef struct packed {
      logic [2:0][OUT_WIDTH-1:0]   fw;
      logic [2:0][COORD_WIDTH-1:0] up;
      logic                        okz;
   } side_type;

endpackage

>>> src/lar_if.sv
interface lar_req_if;
   logic              valid;
   logic              ready;
   lar_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lar_rsp_if;
   logic              valid;
   logic              ready;
   lar_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> src/look_at_rotation_matrix_core.sv
// throughput: one item per cycle; the whole pipeline advances together and holds while a
// finished result waits on the output
// each normalizer runs a 31-stage square root and a 15-stage divider, one bit per stage
// reset (synchronous, active high) clears all valid bits; no item is in flight afterwards
`include "look_at_rotation_matrix_core_defines.svh"

module look_at_rotation_matrix_core (
   input  logic       clock,
   input  logic       reset,
   lar_req_if.sink    req_if,
   lar_rsp_if.source  rsp_if
);

   localparam int PW = lar_pkg::PROD_WIDTH;
   localparam int YW = lar_pkg::Y_WIDTH;

   logic en;

   logic               s0_valid_ff;
   lar_pkg::vec_type   s0_d_ff [3];
   lar_pkg::vec_type   s0_d_in [3];
   lar_pkg::side_type  s0_side_ff, s0_side_in;

   logic               n1_valid, n1_ok;
   lar_pkg::comp_type  n1_vec [3];
   lar_pkg::side_type  n1_side;

   logic                  c1_valid_ff;
   logic signed [PW-1:0]  c1_p_ff [6];
   logic signed [PW-1:0]  c1_p_in [6];
   lar_pkg::comp_type     c1_fw_ff [3];
   logic                  c1_okz_ff;

   logic               c2_valid_ff;
   lar_pkg::vec_type   c2_cr_ff [3];
   lar_pkg::vec_type   c2_cr_in [3];
   lar_pkg::side_type  c2_side_ff, c2_side_in;

   logic               n2_valid, n2_ok;
   lar_pkg::comp_type  n2_vec [3];
   lar_pkg::side_type  n2_side;

   logic                  y1_valid_ff;
   logic signed [YW-1:0]  y1_p_ff [6];
   logic signed [YW-1:0]  y1_p_in [6];
   lar_pkg::comp_type     y1_fw_ff [3];
   lar_pkg::comp_type     y1_fw_in [3];
   lar_pkg::comp_type     y1_rt_ff [3];
   logic                  y1_deg_ff;

   logic                  out_valid_ff;
   lar_pkg::rsp_type      out_data_ff, out_data_in;
   lar_pkg::comp_type     yv [3];

   assign en           = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   always_comb begin
      s0_d_in[0] = lar_pkg::vec_type'(req_if.data.end_x) - lar_pkg::vec_type'(req_if.data.start_x);
      s0_d_in[1] = lar_pkg::vec_type'(req_if.data.end_y) - lar_pkg::vec_type'(req_if.data.start_y);
      s0_d_in[2] = lar_pkg::vec_type'(req_if.data.end_z) - lar_pkg::vec_type'(req_if.data.start_z);
      s0_side_in.fw    = '0;
      s0_side_in.up[0] = req_if.data.up_x;
      s0_side_in.up[1] = req_if.data.up_y;
      s0_side_in.up[2] = req_if.data.up_z;
      s0_side_in.okz   = 1'b0;
   end

   lar_norm u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_vec    (s0_d_ff),
      .in_side   (s0_side_ff),
      .out_valid (n1_valid),
      .out_vec   (n1_vec),
      .out_ok    (n1_ok),
      .out_side  (n1_side)
   );

   // cross(forward, up), products first
   always_comb begin
      c1_p_in[0] = n1_vec[1] * $signed(n1_side.up[2]);
      c1_p_in[1] = n1_vec[2] * $signed(n1_side.up[1]);
      c1_p_in[2] = n1_vec[2] * $signed(n1_side.up[0]);
      c1_p_in[3] = n1_vec[0] * $signed(n1_side.up[2]);
      c1_p_in[4] = n1_vec[0] * $signed(n1_side.up[1]);
      c1_p_in[5] = n1_vec[1] * $signed(n1_side.up[0]);
   end

   always_comb begin
      c2_cr_in[0] = lar_pkg::vec_type'(c1_p_ff[0]) - lar_pkg::vec_type'(c1_p_ff[1]);
      c2_cr_in[1] = lar_pkg::vec_type'(c1_p_ff[2]) - lar_pkg::vec_type'(c1_p_ff[3]);
      c2_cr_in[2] = lar_pkg::vec_type'(c1_p_ff[4]) - lar_pkg::vec_type'(c1_p_ff[5]);
      for (int i = 0; i < 3; i++) begin
         c2_side_in.fw[i] = c1_fw_ff[i];
      end
      c2_side_in.up  = '0;
      c2_side_in.okz = c1_okz_ff;
   end

   lar_norm u_norm_right (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c2_valid_ff),
      .in_vec    (c2_cr_ff),
      .in_side   (c2_side_ff),
      .out_valid (n2_valid),
      .out_vec   (n2_vec),
      .out_ok    (n2_ok),
      .out_side  (n2_side)
   );

   // cross(forward, right), products first
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         y1_fw_in[i] = $signed(n2_side.fw[i]);
      end
      y1_p_in[0] = y1_fw_in[1] * n2_vec[2];
      y1_p_in[1] = y1_fw_in[2] * n2_vec[1];
      y1_p_in[2] = y1_fw_in[2] * n2_vec[0];
      y1_p_in[3] = y1_fw_in[0] * n2_vec[2];
      y1_p_in[4] = y1_fw_in[0] * n2_vec[1];
      y1_p_in[5] = y1_fw_in[1] * n2_vec[0];
   end

   // round to nearest on the magnitude, saturate, restore sign
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [YW:0] yw;
         logic [YW:0]        ym;
         logic [YW:0]        yr;
         yw = y1_p_ff[2*i] - y1_p_ff[2*i+1];
         ym = yw[YW] ? (YW+1)'(-yw) : (YW+1)'(yw);
         yr = (ym + ((YW+1)'(1) << (lar_pkg::OUT_FRAC_BITS - 1))) >> lar_pkg::OUT_FRAC_BITS;
         if (yr > (YW+1)'(lar_pkg::ONE)) begin
            yr = (YW+1)'(lar_pkg::ONE);
         end
         yv[i] = yw[YW] ? -lar_pkg::comp_type'(yr) : lar_pkg::comp_type'(yr);
      end
      out_data_in.right_x    = y1_rt_ff[0];
      out_data_in.right_y    = y1_rt_ff[1];
      out_data_in.right_z    = y1_rt_ff[2];
      out_data_in.upward_x   = yv[0];
      out_data_in.upward_y   = yv[1];
      out_data_in.upward_z   = yv[2];
      out_data_in.forward_x  = y1_fw_ff[0];
      out_data_in.forward_y  = y1_fw_ff[1];
      out_data_in.forward_z  = y1_fw_ff[2];
      out_data_in.degenerate = y1_deg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         c1_valid_ff  <= 1'b0;
         c2_valid_ff  <= 1'b0;
         y1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff  <= req_if.valid;
         c1_valid_ff  <= n1_valid;
         c2_valid_ff  <= c1_valid_ff;
         y1_valid_ff  <= n2_valid;
         out_valid_ff <= y1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_d_ff     <= s0_d_in;
         s0_side_ff  <= s0_side_in;
         c1_p_ff     <= c1_p_in;
         c1_fw_ff    <= n1_vec;
         c1_okz_ff   <= n1_ok;
         c2_cr_ff    <= c2_cr_in;
         c2_side_ff  <= c2_side_in;
         y1_p_ff     <= y1_p_in;
         y1_fw_ff    <= y1_fw_in;
         y1_rt_ff    <= n2_vec;
         y1_deg_ff   <= !(n2_side.okz && n2_ok);
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_data_ff;

   `LAR_ASSERT_IMP(zero_forward_flags_a, clock, reset, out_valid_ff && out_data_ff.forward_x == '0 && out_data_ff.forward_y == '0 && out_data_ff.forward_z == '0, out_data_ff.degenerate)
   `LAR_ASSERT_IMP(zero_right_flags_a, clock, reset, out_valid_ff && out_data_ff.right_x == '0 && out_data_ff.right_y == '0 && out_data_ff.right_z == '0, out_data_ff.degenerate)
   `LAR_ASSERT_NXT(deg_from_ok_a, clock, reset, en && n2_valid && n2_ok && n2_side.okz, !y1_deg_ff)

endmodule

>>> src/lar_norm.sv
`include "look_at_rotation_matrix_core_defines.svh"

module lar_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  lar_pkg::vec_type   in_vec [3],
   input  lar_pkg::side_type  in_side,
   output logic               out_valid,
   output lar_pkg::comp_type  out_vec [3],
   output logic               out_ok,
   output lar_pkg::side_type  out_side
);

   localparam int MW = lar_pkg::MAG_WIDTH;
   localparam int RS = lar_pkg::ROOT_STEPS;
   localparam int QW = lar_pkg::Q_WIDTH;
   localparam int SW = lar_pkg::SUM_WIDTH;
   localparam int RW = lar_pkg::REM_WIDTH;

   typedef struct packed {
      logic [2:0][lar_pkg::W_WIDTH-1:0] w;
      logic [2:0]                       neg;
      logic                             zero;
      lar_pkg::side_type                side;
   } carry_type;

   // stage a: magnitudes and largest one
   logic                 a_valid_ff;
   logic [MW-1:0]        a_mag_ff [3];
   logic [MW-1:0]        a_mag_in [3];
   logic [2:0]           a_neg_ff, a_neg_in;
   logic [MW-1:0]        a_max_ff, a_max_in;
   lar_pkg::side_type    a_side_ff;

   // stage b: leading one
   logic                          b_valid_ff;
   logic [MW-1:0]                 b_mag_ff [3];
   logic [2:0]                    b_neg_ff;
   logic [lar_pkg::POS_WIDTH-1:0] b_pos_ff, b_pos_in;
   logic                          b_zero_ff;
   lar_pkg::side_type             b_side_ff;

   // stage c: common shift, stage d: squares
   logic                          c_valid_ff;
   carry_type                     c_ff, c_in;
   logic                          d_valid_ff;
   logic [lar_pkg::SQ_WIDTH-1:0]  d_sq_ff [3];
   carry_type                     d_c_ff;

   // square root chain, one result bit per stage
   logic [RS:0]   rt_valid_ff;
   logic [SW-1:0] rt_x_ff [0:RS];
   logic [SW-1:0] rt_r_ff [0:RS];
   logic [SW-1:0] rt_x_in [0:RS];
   logic [SW-1:0] rt_r_in [0:RS];
   carry_type     rt_c_ff [0:RS];

   // divider chain, one quotient bit per stage
   logic [QW:0]                     dv_valid_ff;
   logic [RW-1:0]                   dv_rem_ff [0:QW][0:2];
   logic [RW-1:0]                   dv_rem_in [0:QW][0:2];
   logic [QW-1:0]                   dv_low_ff [0:QW][0:2];
   logic [QW-1:0]                   dv_q_ff [0:QW][0:2];
   logic [QW-1:0]                   dv_q_in [0:QW][0:2];
   logic [lar_pkg::ROOT_WIDTH-1:0]  dv_len_ff [0:QW];
   carry_type                       dv_c_ff [0:QW];
   logic [lar_pkg::ROOT_WIDTH-1:0]  len_in;
   logic [lar_pkg::NUM_WIDTH-1:0]   num_in [3];

   logic                  out_valid_ff;
   lar_pkg::comp_type     out_vec_ff [3];
   lar_pkg::comp_type     out_vec_in [3];
   logic                  out_ok_ff;
   lar_pkg::side_type     out_side_ff;

   always_comb begin
      a_max_in = '0;
      for (int i = 0; i < 3; i++) begin
         a_neg_in[i] = in_vec[i][lar_pkg::VEC_WIDTH-1];
         a_mag_in[i] = a_neg_in[i] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
         if (a_mag_in[i] > a_max_in) begin
            a_max_in = a_mag_in[i];
         end
      end
   end

   always_comb begin
      b_pos_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (a_max_ff[i]) begin
            b_pos_in = lar_pkg::POS_WIDTH'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (b_pos_ff >= lar_pkg::POS_WIDTH'(lar_pkg::W_TOP)) begin
            c_in.w[i] = lar_pkg::W_WIDTH'(b_mag_ff[i] >>
                        (b_pos_ff - lar_pkg::POS_WIDTH'(lar_pkg::W_TOP)));
         end else begin
            c_in.w[i] = lar_pkg::W_WIDTH'(b_mag_ff[i] <<
                        (lar_pkg::POS_WIDTH'(lar_pkg::W_TOP) - b_pos_ff));
         end
      end
      c_in.neg  = b_neg_ff;
      c_in.zero = b_zero_ff;
      c_in.side = b_side_ff;
   end

   // restoring square root
   always_comb begin
      rt_x_in[0] = SW'(d_sq_ff[0]) + SW'(d_sq_ff[1]) + SW'(d_sq_ff[2]);
      rt_r_in[0] = '0;
      for (int k = 0; k < RS; k++) begin
         logic [SW-1:0] step_bit;
         logic [SW-1:0] trial;
         step_bit = SW'(1) << (2 * (RS - 1 - k));
         trial    = rt_r_ff[k] + step_bit;
         if (rt_x_ff[k] >= trial) begin
            rt_x_in[k+1] = rt_x_ff[k] - trial;
            rt_r_in[k+1] = (rt_r_ff[k] >> 1) + step_bit;
         end else begin
            rt_x_in[k+1] = rt_x_ff[k];
            rt_r_in[k+1] = rt_r_ff[k] >> 1;
         end
      end
   end

   // numerator w * 2^f + len / 2, then restoring division
   always_comb begin
      len_in = lar_pkg::ROOT_WIDTH'(rt_r_ff[RS]);
      for (int i = 0; i < 3; i++) begin
         num_in[i] = {lar_pkg::NUM_WIDTH'(rt_c_ff[RS].w[i]) << lar_pkg::OUT_FRAC_BITS}
                     + lar_pkg::NUM_WIDTH'(len_in >> 1);
         dv_rem_in[0][i] = RW'(num_in[i] >> QW);
         dv_q_in[0][i]   = '0;
      end
      for (int j = 0; j < QW; j++) begin
         for (int i = 0; i < 3; i++) begin
            logic [RW-1:0] t;
            t = {dv_rem_ff[j][i][RW-2:0], dv_low_ff[j][i][QW-1-j]};
            dv_q_in[j+1][i] = dv_q_ff[j][i];
            if (t >= RW'(dv_len_ff[j])) begin
               dv_rem_in[j+1][i]       = t - RW'(dv_len_ff[j]);
               dv_q_in[j+1][i][QW-1-j] = 1'b1;
            end else begin
               dv_rem_in[j+1][i] = t;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [QW-1:0] q;
         q = dv_q_ff[QW][i];
         if (q > lar_pkg::ONE) begin
            q = lar_pkg::ONE;
         end
         if (dv_c_ff[QW].zero) begin
            out_vec_in[i] = '0;
         end else if (dv_c_ff[QW].neg[i]) begin
            out_vec_in[i] = -lar_pkg::comp_type'(q);
         end else begin
            out_vec_in[i] = lar_pkg::comp_type'(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rt_valid_ff  <= '0;
         dv_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= in_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         rt_valid_ff  <= {rt_valid_ff[RS-1:0], d_valid_ff};
         dv_valid_ff  <= {dv_valid_ff[QW-1:0], rt_valid_ff[RS]};
         out_valid_ff <= dv_valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         a_max_ff  <= a_max_in;
         a_side_ff <= in_side;
         b_mag_ff  <= a_mag_ff;
         b_neg_ff  <= a_neg_ff;
         b_pos_ff  <= b_pos_in;
         b_zero_ff <= (a_max_ff == '0);
         b_side_ff <= a_side_ff;
         c_ff      <= c_in;
         d_c_ff    <= c_ff;
         for (int i = 0; i < 3; i++) begin
            d_sq_ff[i] <= lar_pkg::SQ_WIDTH'(c_ff.w[i]) * lar_pkg::SQ_WIDTH'(c_ff.w[i]);
         end
         rt_c_ff[0] <= d_c_ff;
         for (int k = 0; k <= RS; k++) begin
            rt_x_ff[k] <= rt_x_in[k];
            rt_r_ff[k] <= rt_r_in[k];
         end
         for (int k = 1; k <= RS; k++) begin
            rt_c_ff[k] <= rt_c_ff[k-1];
         end
         dv_len_ff[0] <= len_in;
         dv_c_ff[0]   <= rt_c_ff[RS];
         for (int i = 0; i < 3; i++) begin
            dv_low_ff[0][i] <= num_in[i][QW-1:0];
         end
         for (int j = 0; j <= QW; j++) begin
            dv_rem_ff[j] <= dv_rem_in[j];
            dv_q_ff[j]   <= dv_q_in[j];
         end
         for (int j = 1; j <= QW; j++) begin
            dv_len_ff[j] <= dv_len_ff[j-1];
            dv_c_ff[j]   <= dv_c_ff[j-1];
            dv_low_ff[j] <= dv_low_ff[j-1];
         end
         out_vec_ff  <= out_vec_in;
         out_ok_ff   <= !dv_c_ff[QW].zero;
         out_side_ff <= dv_c_ff[QW].side;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vec   = out_vec_ff;
   assign out_ok    = out_ok_ff;
   assign out_side  = out_side_ff;

   `LAR_ASSERT_IMP(shift_lands_in_range_a, clock, reset, c_valid_ff && !c_ff.zero, c_ff.w[0][lar_pkg::W_TOP] || c_ff.w[1][lar_pkg::W_TOP] || c_ff.w[2][lar_pkg::W_TOP])
   `LAR_ASSERT_IMP(root_not_small_a, clock, reset, dv_valid_ff[0] && !dv_c_ff[0].zero, dv_len_ff[0][lar_pkg::ROOT_WIDTH-1:lar_pkg::W_TOP] != '0)
   `LAR_ASSERT_IMP(zero_vec_out_a, clock, reset, out_valid_ff && !out_ok_ff, out_vec_ff[0] == '0 && out_vec_ff[1] == '0 && out_vec_ff[2] == '0)

endmodule

>>> verif/tb_look_at_rotation_matrix_core.sv
module tb_look_at_rotation_matrix_core;

   localparam int LATENCY     = 111;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lar_req_if req_if ();
   lar_rsp_if rsp_if ();

   look_at_rotation_matrix_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // orientation predictor
   // ---------------------------------------------------------------
   function automatic logic [63:0] abs64(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // returns 0 for a zero-length vector
   function automatic bit unit_vec(input longint v[3], output longint o[3]);
      logic [63:0] m[3];
      logic [63:0] mx, s, len, q, one;
      int rs, ls;
      mx = 0;
      s = 0;
      rs = 0;
      ls = 0;
      one = 64'd1 << lar_pkg::OUT_FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         m[i] = abs64(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) o[i] = 0;
         return 1'b0;
      end
      while (mx >= (64'd1 << 30)) begin
         mx = mx >> 1;
         rs++;
      end
      while (mx < (64'd1 << 29)) begin
         mx = mx << 1;
         ls++;
      end
      for (int i = 0; i < 3; i++) begin
         m[i] = (m[i] >> rs) << ls;
         s = s + m[i] * m[i];
      end
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << lar_pkg::OUT_FRAC_BITS) + (len >> 1)) / len;
         if (q > one) q = one;
         o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic void cross_of(input longint a[3], input longint b[3],
                                    output longint o[3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic lar_pkg::rsp_type look_at_axes(lar_pkg::req_type r);
      longint dv[3], upv[3], fw[3], cr[3], rt[3], yw[3];
      logic [63:0] m, one;
      lar_pkg::comp_type yv[3];
      bit okz, okx;
      lar_pkg::rsp_type o;
      one = 64'd1 << lar_pkg::OUT_FRAC_BITS;
      dv[0] = longint'(r.end_x) - longint'(r.start_x);
      dv[1] = longint'(r.end_y) - longint'(r.start_y);
      dv[2] = longint'(r.end_z) - longint'(r.start_z);
      upv[0] = longint'(r.up_x);
      upv[1] = longint'(r.up_y);
      upv[2] = longint'(r.up_z);
      okz = unit_vec(dv, fw);
      cross_of(fw, upv, cr);
      okx = unit_vec(cr, rt);
      cross_of(fw, rt, yw);
      for (int i = 0; i < 3; i++) begin
         m = (abs64(yw[i]) + (64'd1 << (lar_pkg::OUT_FRAC_BITS - 1)))
             >> lar_pkg::OUT_FRAC_BITS;
         if (m > one) m = one;
         yv[i] = lar_pkg::comp_type'(yw[i] < 0 ? -longint'(m) : longint'(m));
      end
      o.right_x    = lar_pkg::comp_type'(rt[0]);
      o.right_y    = lar_pkg::comp_type'(rt[1]);
      o.right_z    = lar_pkg::comp_type'(rt[2]);
      o.upward_x   = yv[0];
      o.upward_y   = yv[1];
      o.upward_z   = yv[2];
      o.forward_x  = lar_pkg::comp_type'(fw[0]);
      o.forward_y  = lar_pkg::comp_type'(fw[1]);
      o.forward_z  = lar_pkg::comp_type'(fw[2]);
      o.degenerate = !(okz && okx);
      return o;
   endfunction

   class axes_scoreboard;
      lar_pkg::rsp_type pending[$];
      int               errors;

      function void note_request(lar_pkg::req_type r);
         pending.push_back(look_at_axes(r));
      endfunction

      function void check_result(lar_pkg::rsp_type got);
         lar_pkg::rsp_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %h actual %h", exp, got);
         end
      endfunction
   endclass

   axes_scoreboard board = new();

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   bit hold_off = 1'b0;
   bit sending_done = 1'b0;

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic lar_pkg::coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: return lar_pkg::coord_type'({1'b1, 31'd0});
         1: return lar_pkg::coord_type'({1'b0, {31{1'b1}}});
         2: return lar_pkg::coord_type'($urandom_range(0, 8)) - 4;
         3: return lar_pkg::coord_type'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
         default: return lar_pkg::coord_type'($urandom);
      endcase
   endfunction

   // leaves valid high; the caller drops it or offers the next item
   task automatic send_item(lar_pkg::req_type r);
      req_if.data  <= r;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      board.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_random(int n);
      lar_pkg::req_type r;
      int g;
      for (int k = 0; k < n; k++) begin
         r.start_x = rand_coord();
         r.start_y = rand_coord();
         r.start_z = rand_coord();
         r.end_x = rand_coord();
         r.end_y = rand_coord();
         r.end_z = rand_coord();
         r.up_x = rand_coord();
         r.up_y = rand_coord();
         r.up_z = rand_coord();
         case ($urandom_range(0, 9))
            0: {r.end_x, r.end_y, r.end_z} = {r.start_x, r.start_y, r.start_z};
            1: {r.up_x, r.up_y, r.up_z} = '0;
            // up parallel to the view direction
            2: begin
               r.end_x = r.start_x + 3 * (lar_pkg::coord_type'($urandom_range(0, 4)) - 2);
               r.end_y = r.start_y + 3 * (lar_pkg::coord_type'($urandom_range(0, 4)) - 2);
               r.end_z = r.start_z + 3 * (lar_pkg::coord_type'($urandom_range(0, 4)) - 2);
               r.up_x = 5 * (r.end_x - r.start_x);
               r.up_y = 5 * (r.end_y - r.start_y);
               r.up_z = 5 * (r.end_z - r.start_z);
            end
            default: ;
         endcase
         g = gap_len();
         // idle gap; stream continues back to back when zero
         if (g > 0) begin
            req_if.valid <= 1'b0;
            repeat (g) @(negedge clock);
         end
         req_if.data  <= r;
         req_if.valid <= 1'b1;
         do @(posedge clock); while (!req_if.ready);
         board.note_request(r);
         @(negedge clock);
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic send_directed();
      lar_pkg::coord_type mx, mn;
      lar_pkg::req_type r;
      mx = lar_pkg::coord_type'({1'b0, {31{1'b1}}});
      mn = lar_pkg::coord_type'({1'b1, 31'd0});
      r = '0;
      send_item(r);
      r.end_z = 32'sh10000; r.up_y = 32'sh10000;
      send_item(r);
      r.up_y = 0;
      send_item(r);
      r.up_z = 32'sh20000;
      send_item(r);
      r = '0;
      r.start_x = mn; r.start_y = mn; r.start_z = mn;
      r.end_x = mx; r.end_y = mx; r.end_z = mx;
      r.up_x = mx; r.up_y = mn; r.up_z = mx;
      send_item(r);
      r.start_x = mx; r.start_y = mx; r.start_z = mx;
      r.end_x = mn; r.end_y = mn; r.end_z = mn;
      r.up_x = mn; r.up_y = mn; r.up_z = mx;
      send_item(r);
      r = '0;
      r.end_x = 1; r.up_z = mn;
      send_item(r);
      r = '0;
      r.end_x = mx; r.end_y = 1; r.up_x = mx; r.up_y = 1; r.up_z = 1;
      send_item(r);
      r = '1;
      send_item(r);
      r = '0;
      r.end_x = -1; r.end_y = -1; r.end_z = -1; r.up_x = -1; r.up_y = 1;
      send_item(r);
      r = '0;
      r.start_y = 7; r.end_y = mx; r.up_x = 1; r.up_y = mn;
      send_item(r);
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_directed();
      // long output stall while inputs keep coming
      fork
         begin
            hold_off = 1'b1;
            repeat (1500) @(posedge clock);
            hold_off = 1'b0;
         end
         send_random(300);
      join
      @(negedge clock);
      send_random(1400);
      sending_done = 1'b1;
   end

   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
            @(negedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap_len() + 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.data);
   end

   // ---------------------------------------------------------------
   // end of run
   // ---------------------------------------------------------------
   int cycles = 0;

   initial begin
      fork
         begin
            wait (sending_done);
            while (board.pending.size() != 0) @(posedge clock);
            repeat (LATENCY + 50) @(posedge clock);
         end
         begin
            while (cycles < CYCLE_LIMIT) begin
               @(posedge clock);
               cycles++;
            end
            board.errors++;
         end
      join_any
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/lar_pkg.sv
src/lar_if.sv
src/lar_norm.sv
src/look_at_rotation_matrix_core.sv
verif/tb_look_at_rotation_matrix_core.sv
